// ===== rtl/ror_pkg.sv =====
// Shared types and constants for the record ring with offset lookup.
// Used by ror_cmp and ring_of_records_with_offset_lookup.
`default_nettype none

package ror_pkg;

  localparam int SIZE_W   = 16;
  localparam int HANDLE_W = 32;
  localparam int OFF_W    = 20;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_FIND = 1'b1;

  typedef struct packed {
    logic              hit;
    logic [SIZE_W-1:0] rel;
  } cmp_res_t;

endpackage

`default_nettype wire

// ===== rtl/ring_of_records_with_offset_lookup.sv =====
// Top level: ring of DEPTH records (handle, length) with offset lookup.
// Depends on ror_pkg and ror_cmp.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------------------
//   in      | input     | in_valid / in_ready   | kind, entry_size, entry_handle, char_pos
//   out     | output    | out_valid / out_ready | found, found_handle, found_size,
//           |           |                       | byte_offset, dropped_oldest
//
// An add passes from acceptance through DONE into the output register.
// A find passes through LOAD, one WALK step per record walked (at most the stored count,
// at most DEPTH) and DONE, or straight to DONE on an empty ring: one record per cycle
// through the single compare unit, fed by the registered read port of the record memory.
// in_ready is high only while the sequencer is idle; a waiting result in the output
// register does not block the next transaction until a second result is due.
// Synchronous reset empties the ring; record contents are not cleared.
`default_nettype none

module ring_of_records_with_offset_lookup
  import ror_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                kind,
  input  wire logic [SIZE_W-1:0]   entry_size,
  input  wire logic [HANDLE_W-1:0] entry_handle,
  input  wire logic [OFF_W-1:0]    char_pos,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     found,
  output logic [HANDLE_W-1:0]      found_handle,
  output logic [SIZE_W-1:0]        found_size,
  output logic [SIZE_W-1:0]        byte_offset,
  output logic                     dropped_oldest
);

  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = SIZE_W + CNT_W;
  localparam int BASE_W = ((SUM_W > OFF_W) ? SUM_W : OFF_W) + 1;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [SIZE_W-1:0]   size_mem   [DEPTH];
  logic [HANDLE_W-1:0] handle_mem [DEPTH];

  logic [1:0]          state;
  logic [SLOT_W-1:0]   write_slot;
  logic [SLOT_W-1:0]   read_slot;
  logic [CNT_W-1:0]    stored_count;
  logic [SLOT_W-1:0]   slot;
  logic [CNT_W-1:0]    idx;
  logic [BASE_W-1:0]   base;
  logic [OFF_W-1:0]    offset;
  logic [SIZE_W-1:0]   size_q;
  logic [HANDLE_W-1:0] handle_q;

  logic                res_found;
  logic [HANDLE_W-1:0] res_handle;
  logic [SIZE_W-1:0]   res_size;
  logic [SIZE_W-1:0]   res_boff;
  logic                res_dropped;

  logic                in_fire;
  logic                add_fire;
  logic [SLOT_W-1:0]   write_slot_next;
  logic [SLOT_W-1:0]   slot_next;
  cmp_res_t            cmp;
  logic [BASE_W-1:0]   base_next;

  assign in_ready        = (state == ST_IDLE);
  assign in_fire         = in_valid && in_ready;
  assign add_fire        = in_fire && (kind == KIND_ADD);
  assign write_slot_next = (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
  assign slot_next       = (slot == LAST_SLOT) ? '0 : slot + 1'b1;

  ror_cmp #(
    .BASE_W (BASE_W)
  ) u_cmp (
    .offset    (offset),
    .base      (base),
    .len       (size_q),
    .res       (cmp),
    .base_next (base_next)
  );

  // record memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (add_fire) begin
      size_mem[write_slot]   <= entry_size;
      handle_mem[write_slot] <= entry_handle;
    end
    size_q   <= size_mem[slot];
    handle_q <= handle_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      write_slot   <= '0;
      read_slot    <= '0;
      stored_count <= '0;
      slot         <= '0;
      idx          <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            res_found   <= 1'b0;
            res_handle  <= '0;
            res_size    <= '0;
            res_boff    <= '0;
            res_dropped <= 1'b0;
            if (kind == KIND_ADD) begin
              write_slot <= write_slot_next;
              if (stored_count == FULL_CNT) begin
                read_slot   <= write_slot_next;
                res_dropped <= 1'b1;
              end else begin
                stored_count <= stored_count + 1'b1;
              end
              state <= ST_DONE;
            end else begin
              offset <= char_pos;
              base   <= '0;
              idx    <= '0;
              slot   <= read_slot;
              state  <= (stored_count == '0) ? ST_DONE : ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          slot  <= slot_next;
          state <= ST_WALK;
        end
        ST_WALK: begin
          slot <= slot_next;
          base <= base_next;
          idx  <= idx + 1'b1;
          if (cmp.hit) begin
            res_found  <= 1'b1;
            res_handle <= handle_q;
            res_size   <= size_q;
            res_boff   <= cmp.rel;
            state      <= ST_DONE;
          end else if ((idx + 1'b1) == stored_count) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            found          <= res_found;
            found_handle   <= res_handle;
            found_size     <= res_size;
            byte_offset    <= res_boff;
            dropped_oldest <= res_dropped;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    stored_count <= FULL_CNT)
    else $error("stored count beyond ring depth");

  a_full_slots : assert property (@(posedge clk) disable iff (rst)
    (stored_count == FULL_CNT) |-> (read_slot == write_slot))
    else $error("full ring with read and write slots apart");

  a_walk_index : assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (idx < stored_count))
    else $error("walk past stored records");

  a_found_excl : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(found && dropped_oldest))
    else $error("result both found and dropped");

  a_miss_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |->
      (found_handle == '0 && found_size == '0 && byte_offset == '0))
    else $error("miss with nonzero record fields");

endmodule

`default_nettype wire

// ===== rtl/ror_cmp.sv =====
// Shared compare unit of the find walk: tests one record against the offset.
// Depends on ror_pkg.
`default_nettype none

module ror_cmp
  import ror_pkg::*;
#(
  parameter int BASE_W = 23
) (
  input  wire logic [OFF_W-1:0]  offset,
  input  wire logic [BASE_W-1:0] base,
  input  wire logic [SIZE_W-1:0] len,
  output cmp_res_t               res,
  output logic [BASE_W-1:0]      base_next
);

  logic [BASE_W-1:0] diff;
  logic [BASE_W-1:0] len_ext;

  assign len_ext   = BASE_W'(len);
  assign diff      = BASE_W'(offset) - base;
  assign base_next = base + len_ext;

  always_comb begin
    res.hit = (len != '0) && !diff[BASE_W-1] && (diff < len_ext);
    res.rel = diff[SIZE_W-1:0];
  end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for ring_of_records_with_offset_lookup: a directed table, then random adds
// and finds, each checked against the table's result or an in-bench model of the ring.
// Depends on ror_pkg and the block's RTL.

module testbench;
  import ror_pkg::*;

  localparam int RING_DEPTH = 16;
  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int RANDOM_PER_PHASE = 207;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic                kind;
    logic [SIZE_W-1:0]   size;
    logic [HANDLE_W-1:0] handle;
    logic [OFF_W-1:0]    offset;
  } ring_item_t;

  typedef struct packed {
    logic                found;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
    logic [SIZE_W-1:0]   boff;
    logic                dropped;
  } ring_result_t;

  typedef struct {
    ring_item_t   item;
    int           reps;
    bit           typed;
    ring_result_t res;
  } table_row_t;

  localparam ring_result_t ZERO_RES = '0;
  localparam ring_result_t DROPPED_RES = '{found: 1'b0, handle: '0, size: '0, boff: '0,
                                           dropped: 1'b1};

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic                kind;
  logic [SIZE_W-1:0]   entry_size;
  logic [HANDLE_W-1:0] entry_handle;
  logic [OFF_W-1:0]    char_pos;
  logic                out_valid;
  logic                out_ready;
  logic                found;
  logic [HANDLE_W-1:0] found_handle;
  logic [SIZE_W-1:0]   found_size;
  logic [SIZE_W-1:0]   byte_offset;
  logic                dropped_oldest;

  ring_of_records_with_offset_lookup #(.DEPTH(RING_DEPTH)) uut (.*);

  always #2 clk = ~clk;

  // Model of the ring
  logic [SIZE_W-1:0]   ring_len [RING_DEPTH];
  logic [HANDLE_W-1:0] ring_hdl [RING_DEPTH];
  logic [SLOT_W-1:0]   wr_slot;
  logic [SLOT_W-1:0]   rd_slot;
  int unsigned         n_stored;

  ring_result_t awaited_answers[$];
  ring_result_t head_answer;
  table_row_t   directed_rows[$];
  int           error_count = 0;
  int           src_gap_pct = 0;
  int           sink_gap_pct = 0;
  bit           long_hold_req = 1'b0;
  int           hold_left = 0;

  function automatic logic [SLOT_W-1:0] next_slot(logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(RING_DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic ring_result_t apply_to_ring(ring_item_t it);
    ring_result_t r;
    logic [SLOT_W-1:0] s;
    int unsigned base;
    r = '0;
    if (it.kind == KIND_ADD) begin
      ring_len[wr_slot] = it.size;
      ring_hdl[wr_slot] = it.handle;
      wr_slot = next_slot(wr_slot);
      if (n_stored >= RING_DEPTH) begin
        rd_slot = wr_slot;
        r.dropped = 1'b1;
      end else begin
        n_stored++;
      end
    end else begin
      s = rd_slot;
      base = 0;
      for (int i = 0; i < n_stored; i++) begin
        if (ring_len[s] != 0 && it.offset >= base && it.offset - base < ring_len[s]) begin
          r.found = 1'b1;
          r.handle = ring_hdl[s];
          r.size = ring_len[s];
          r.boff = SIZE_W'(it.offset - base);
          break;
        end
        base += ring_len[s];
        s = next_slot(s);
      end
    end
    return r;
  endfunction

  function automatic int unsigned bytes_ahead(int unsigned count);
    logic [SLOT_W-1:0] s;
    int unsigned sum;
    s = rd_slot;
    sum = 0;
    for (int i = 0; i < count; i++) begin
      sum += ring_len[s];
      s = next_slot(s);
    end
    return sum;
  endfunction

  function automatic ring_item_t random_item();
    ring_item_t it;
    int unsigned total, j, start, len;
    it.kind = ($urandom_range(99) < 45) ? KIND_ADD : KIND_FIND;
    it.size = SIZE_W'($urandom);
    it.handle = $urandom;
    it.offset = OFF_W'($urandom);
    if (it.kind == KIND_ADD) begin
      case ($urandom_range(9))
        0: it.size = '0;
        1: it.size = '1;
        2: ;
        default: it.size = SIZE_W'($urandom_range(64, 1));
      endcase
    end else if (n_stored != 0) begin
      total = bytes_ahead(n_stored);
      j = $urandom_range(n_stored - 1);
      start = bytes_ahead(j);
      len = ring_len[SLOT_W'(rd_slot + SLOT_W'(j))];
      case ($urandom_range(6))
        0: it.offset = OFF_W'(start);
        1: it.offset = OFF_W'((len == 0) ? start : start + len - 1);
        2: it.offset = OFF_W'(start + $urandom_range(len));
        3: it.offset = OFF_W'(total);
        4, 5: if (total != 0) it.offset = OFF_W'($urandom_range(total - 1));
        default: ;
      endcase
    end
    return it;
  endfunction

  task automatic note_mismatch(input string msg);
    error_count++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic tab(input logic k, input logic [SIZE_W-1:0] sz,
                     input logic [HANDLE_W-1:0] hd, input logic [OFF_W-1:0] off,
                     input int reps, input bit typed, input ring_result_t res);
    table_row_t row;
    row.item = '{kind: k, size: sz, handle: hd, offset: off};
    row.reps = reps;
    row.typed = typed;
    row.res = res;
    directed_rows.push_back(row);
  endtask

  task automatic offer(input ring_item_t it, input bit typed, input ring_result_t res);
    ring_result_t predicted;
    @(negedge clk);
    while (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= it.kind;
    entry_size <= it.size;
    entry_handle <= it.handle;
    char_pos <= it.offset;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_to_ring(it);
    awaited_answers.push_back(typed ? res : predicted);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    kind = KIND_ADD;
    entry_size = '0;
    entry_handle = '0;
    char_pos = '0;
    wr_slot = '0;
    rd_slot = '0;
    n_stored = 0;

    tab(KIND_FIND, '0, '0, '0, 1, 1'b1, ZERO_RES);
    tab(KIND_FIND, '0, '0, '1, 1, 1'b1, ZERO_RES);
    tab(KIND_ADD, 16'd10, 32'h1234_5678, '0, 1, 1'b1, ZERO_RES);
    tab(KIND_ADD, 16'd0, 32'h0000_0000, '0, 1, 1'b1, ZERO_RES);
    tab(KIND_ADD, 16'hFFFF, 32'hFFFF_FFFF, '1, 1, 1'b1, ZERO_RES);
    tab(KIND_FIND, '0, '0, 20'd0, 1, 1'b1,
        '{1'b1, 32'h1234_5678, 16'd10, 16'd0, 1'b0});
    tab(KIND_FIND, '1, '1, 20'd9, 1, 1'b1,
        '{1'b1, 32'h1234_5678, 16'd10, 16'd9, 1'b0});
    tab(KIND_FIND, '0, '0, 20'd10, 1, 1'b1,
        '{1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 1'b0});
    tab(KIND_FIND, '0, '0, 20'd65544, 1, 1'b1,
        '{1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFE, 1'b0});
    tab(KIND_FIND, '0, '0, 20'd65545, 1, 1'b1, ZERO_RES);
    tab(KIND_FIND, '0, '0, '1, 1, 1'b1, ZERO_RES);
    tab(KIND_ADD, 16'd1, 32'h0000_0100, '0, 13, 1'b1, ZERO_RES);
    tab(KIND_ADD, 16'd5, 32'h8000_0000, '0, 1, 1'b1, DROPPED_RES);
    tab(KIND_FIND, '0, '0, 20'd0, 1, 1'b0, ZERO_RES);
    tab(KIND_FIND, '0, '0, 20'd65535, 1, 1'b0, ZERO_RES);
    tab(KIND_FIND, '0, '0, 20'd65548, 1, 1'b0, ZERO_RES);
    tab(KIND_FIND, '0, '0, 20'd65552, 1, 1'b0, ZERO_RES);
    tab(KIND_FIND, '0, '0, 20'd65553, 1, 1'b0, ZERO_RES);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    src_gap_pct = 29;
    sink_gap_pct = 55;
    foreach (directed_rows[i]) begin
      for (int r = 0; r < directed_rows[i].reps; r++) begin
        ring_item_t it;
        it = directed_rows[i].item;
        it.handle = it.handle + HANDLE_W'(r);
        offer(it, directed_rows[i].typed, directed_rows[i].res);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      src_gap_pct = (phase == 0) ? 29 : (phase == 1) ? 55 : 0;
      sink_gap_pct = (phase == 0) ? 55 : (phase == 1) ? 29 : 0;
      // back up the block while items keep coming
      if (phase == 2) long_hold_req = 1'b1;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) offer(random_item(), 1'b0, ZERO_RES);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (long_hold_req && hold_left == 0) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (sink_gap_pct == 0) || ($urandom_range(99) >= sink_gap_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (awaited_answers.size() == 0) begin
        note_mismatch("result with nothing awaited");
      end else begin
        head_answer = awaited_answers.pop_front();
        if (found !== head_answer.found)
          note_mismatch($sformatf("found got %0b want %0b", found, head_answer.found));
        if (found_handle !== head_answer.handle)
          note_mismatch($sformatf("found_handle got %h want %h", found_handle,
                                  head_answer.handle));
        if (found_size !== head_answer.size)
          note_mismatch($sformatf("found_size got %h want %h", found_size,
                                  head_answer.size));
        if (byte_offset !== head_answer.boff)
          note_mismatch($sformatf("byte_offset got %h want %h", byte_offset,
                                  head_answer.boff));
        if (dropped_oldest !== head_answer.dropped)
          note_mismatch($sformatf("dropped_oldest got %0b want %0b", dropped_oldest,
                                  head_answer.dropped));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
